/* src/qam_nearest_point_demapper_defines.svh */
// Assertion macros used by the demapper RTL.
`ifndef QAM_NEAREST_POINT_DEMAPPER_DEFINES_SVH
`define QAM_NEAREST_POINT_DEMAPPER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define QND_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define QND_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/qnd_pkg.sv */
// Shared types, constants and helper functions for the QAM nearest-point demapper.
`default_nettype none

package qnd_pkg;

	localparam int LEVEL_WIDTH      = 16;
	localparam int TABLE_LEVELS     = 8;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int MAX_LEVELS_DEF   = 8;
	localparam int SYMBOL_WIDTH     = 6;
	localparam int COUNT_WIDTH      = 3;
	localparam int CFG_DATA_WIDTH   = 64;
	localparam int CFG_INDEX_WIDTH  = 2;
	localparam int ORDER_WIDTH      = 2;
	localparam int HALF_BITS_WIDTH  = 2;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ORDER      = 2'd0,
		REG_LEVEL_LOW  = 2'd1,
		REG_LEVEL_HIGH = 2'd2
	} reg_index_t;

	typedef enum logic [ORDER_WIDTH-1:0] {
		ORDER_QPSK     = 2'd0,
		ORDER_QAM16    = 2'd1,
		ORDER_QAM64    = 2'd2,
		ORDER_RESERVED = 2'd3
	} order_t;

	typedef struct packed {
		logic [HALF_BITS_WIDTH-1:0] half_bits;
		logic [COUNT_WIDTH-1:0]     bit_count;
	} ctl_t;

	// Bits per axis of the largest power-of-two grid not above max_levels.
	function automatic int half_bits_max(input int max_levels);
		return $clog2(max_levels + 1) - 1;
	endfunction

	// Width of one squared axis distance.
	function automatic int dist_width(input int sample_width);
		int ext_width;
		ext_width = ((sample_width > LEVEL_WIDTH) ? sample_width : LEVEL_WIDTH) + 1;
		return 2 * ext_width;
	endfunction

endpackage

`default_nettype wire

/* src/qnd_cfg.sv */
// Configuration registers and derived grid size for the demapper.
`default_nettype none

module qnd_cfg #(
	parameter int IDX_WIDTH = qnd_pkg::half_bits_max(qnd_pkg::MAX_LEVELS_DEF)
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            write_enable,
	input  logic [qnd_pkg::CFG_INDEX_WIDTH-1:0]             write_index,
	input  logic [qnd_pkg::CFG_DATA_WIDTH-1:0]              write_data,
	output qnd_pkg::ctl_t                                   ctl,
	output logic [qnd_pkg::TABLE_LEVELS-1:0][qnd_pkg::LEVEL_WIDTH-1:0] levels
);
	import qnd_pkg::*;

	localparam logic [HALF_BITS_WIDTH-1:0] HB_MAX = HALF_BITS_WIDTH'(IDX_WIDTH);

	order_t                    order_q;
	logic [CFG_DATA_WIDTH-1:0] level_low_q;
	logic [CFG_DATA_WIDTH-1:0] level_high_q;
	order_t                    order_sat;
	logic [HALF_BITS_WIDTH-1:0] hb_want;
	logic [HALF_BITS_WIDTH-1:0] hb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q      <= ORDER_QPSK;
			level_low_q  <= '0;
			level_high_q <= '0;
		end else if (write_enable) begin
			case (reg_index_t'(write_index))
				REG_ORDER:      order_q      <= order_t'(write_data[ORDER_WIDTH-1:0]);
				REG_LEVEL_LOW:  level_low_q  <= write_data;
				REG_LEVEL_HIGH: level_high_q <= write_data;
				default: ;
			endcase
		end
	end

	// Reserved order code falls back to 64-QAM.
	assign order_sat = (order_q == ORDER_RESERVED) ? ORDER_QAM64 : order_q;
	assign hb_want   = HALF_BITS_WIDTH'(order_sat) + HALF_BITS_WIDTH'(1);
	assign hb        = (hb_want > HB_MAX) ? HB_MAX : hb_want;

	assign ctl.half_bits = hb;
	assign ctl.bit_count = {hb, 1'b0};
	assign levels        = {level_high_q, level_low_q};

endmodule

`default_nettype wire

/* src/qnd_cell.sv */
// One cell of the level chain: score one grid level on both axes and keep the best so far.
`default_nettype none

module qnd_cell #(
	parameter int SAMPLE_WIDTH = qnd_pkg::SAMPLE_WIDTH_DEF,
	parameter int IDX_WIDTH    = qnd_pkg::half_bits_max(qnd_pkg::MAX_LEVELS_DEF),
	parameter int DIST_WIDTH   = qnd_pkg::dist_width(qnd_pkg::SAMPLE_WIDTH_DEF),
	parameter int CELL_INDEX   = 0
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  qnd_pkg::ctl_t                          ctl,
	input  logic signed [qnd_pkg::LEVEL_WIDTH-1:0] level,
	input  logic                                   up_valid,
	output logic                                   up_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]         up_i,
	input  logic signed [SAMPLE_WIDTH-1:0]         up_q,
	input  logic [DIST_WIDTH-1:0]                  up_dist_i,
	input  logic [DIST_WIDTH-1:0]                  up_dist_q,
	input  logic [IDX_WIDTH-1:0]                   up_idx_i,
	input  logic [IDX_WIDTH-1:0]                   up_idx_q,
	output logic                                   dn_valid,
	input  logic                                   dn_ready,
	output logic signed [SAMPLE_WIDTH-1:0]         dn_i,
	output logic signed [SAMPLE_WIDTH-1:0]         dn_q,
	output logic [DIST_WIDTH-1:0]                  dn_dist_i,
	output logic [DIST_WIDTH-1:0]                  dn_dist_q,
	output logic [IDX_WIDTH-1:0]                   dn_idx_i,
	output logic [IDX_WIDTH-1:0]                   dn_idx_q
);
	import qnd_pkg::*;

	`include "qam_nearest_point_demapper_defines.svh"

	localparam int                 EXT_WIDTH = DIST_WIDTH / 2;
	localparam bit                 FIRST     = (CELL_INDEX == 0);
	localparam logic [IDX_WIDTH-1:0] MY_IDX  = IDX_WIDTH'(CELL_INDEX);
	localparam logic [IDX_WIDTH:0] MY_POS    = (IDX_WIDTH + 1)'(CELL_INDEX);

	logic                          v_q;
	logic signed [SAMPLE_WIDTH-1:0] i_q;
	logic signed [SAMPLE_WIDTH-1:0] q_q;
	logic [DIST_WIDTH-1:0]         dist_i_q;
	logic [DIST_WIDTH-1:0]         dist_q_q;
	logic [IDX_WIDTH-1:0]          idx_i_q;
	logic [IDX_WIDTH-1:0]          idx_q_q;

	logic signed [EXT_WIDTH-1:0]   diff_i;
	logic signed [EXT_WIDTH-1:0]   diff_q;
	logic signed [DIST_WIDTH-1:0]  sq_i;
	logic signed [DIST_WIDTH-1:0]  sq_q;
	logic [IDX_WIDTH:0]            level_count;
	logic                          cell_en;
	logic                          take_i;
	logic                          take_q;
	logic                          load;

	assign diff_i = EXT_WIDTH'(up_i) - EXT_WIDTH'(level);
	assign diff_q = EXT_WIDTH'(up_q) - EXT_WIDTH'(level);
	assign sq_i   = diff_i * diff_i;
	assign sq_q   = diff_q * diff_q;

	assign level_count = (IDX_WIDTH + 1)'(1) << ctl.half_bits;
	assign cell_en     = (MY_POS < level_count);

	// Strict compare keeps the lower-index level on a tie.
	assign take_i = FIRST || (cell_en && ($unsigned(sq_i) < up_dist_i));
	assign take_q = FIRST || (cell_en && ($unsigned(sq_q) < up_dist_q));

	assign up_ready = !v_q || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			i_q      <= up_i;
			q_q      <= up_q;
			dist_i_q <= take_i ? $unsigned(sq_i) : up_dist_i;
			dist_q_q <= take_q ? $unsigned(sq_q) : up_dist_q;
			idx_i_q  <= take_i ? MY_IDX : up_idx_i;
			idx_q_q  <= take_q ? MY_IDX : up_idx_q;
		end
	end

	assign dn_valid  = v_q;
	assign dn_i      = i_q;
	assign dn_q      = q_q;
	assign dn_dist_i = dist_i_q;
	assign dn_dist_q = dist_q_q;
	assign dn_idx_i  = idx_i_q;
	assign dn_idx_q  = idx_q_q;

	`QND_ASSERT_NOW(a_idx_bound, v_q, (idx_i_q <= MY_IDX) && (idx_q_q <= MY_IDX), "best index beyond cell")
	`QND_ASSERT_NEXT(a_skip_keeps, load && !cell_en, (idx_i_q == $past(up_idx_i)) && (idx_q_q == $past(up_idx_q)), "disabled cell changed best index")
	`QND_ASSERT_NEXT(a_hold_item, v_q && !dn_ready, v_q, "stalled cell dropped its item")

endmodule

`default_nettype wire

/* src/qam_nearest_point_demapper.sv */
// Top level of the QAM nearest-point demapper: configuration and chain of level cells.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------
//   config   | write_enable               | write_index, write_data
//   sample   | sample_valid, sample_stall | in_phase, quadrature
//   symbol   | symbol_valid, symbol_stall | symbol_bits, bit_count
//
// One sample a cycle while symbol_stall is low; each cell registers its item on the way through.
// The chain holds one cell per grid level, each scoring both axes against its level.
// Reset selects QPSK with all levels zero and empties the chain.
// Gaps in the chain close up under symbol_stall; sample_stall rises only once every
// cell holds an item.
`default_nettype none

module qam_nearest_point_demapper #(
	parameter int SAMPLE_WIDTH = qnd_pkg::SAMPLE_WIDTH_DEF,
	parameter int MAX_LEVELS   = qnd_pkg::MAX_LEVELS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   write_enable,
	input  logic [qnd_pkg::CFG_INDEX_WIDTH-1:0]    write_index,
	input  logic [qnd_pkg::CFG_DATA_WIDTH-1:0]     write_data,
	input  logic                                   sample_valid,
	output logic                                   sample_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]         in_phase,
	input  logic signed [SAMPLE_WIDTH-1:0]         quadrature,
	output logic                                   symbol_valid,
	input  logic                                   symbol_stall,
	output logic [qnd_pkg::SYMBOL_WIDTH-1:0]       symbol_bits,
	output logic [qnd_pkg::COUNT_WIDTH-1:0]        bit_count
);
	import qnd_pkg::*;

	localparam int IDX_WIDTH  = half_bits_max(MAX_LEVELS);
	localparam int NUM_CELLS  = 1 << IDX_WIDTH;
	localparam int DIST_WIDTH = dist_width(SAMPLE_WIDTH);

	ctl_t                                     ctl;
	logic [TABLE_LEVELS-1:0][LEVEL_WIDTH-1:0] levels;

	logic                           ch_valid  [NUM_CELLS+1];
	logic                           ch_ready  [NUM_CELLS+1];
	logic signed [SAMPLE_WIDTH-1:0] ch_i      [NUM_CELLS+1];
	logic signed [SAMPLE_WIDTH-1:0] ch_q      [NUM_CELLS+1];
	logic [DIST_WIDTH-1:0]          ch_dist_i [NUM_CELLS+1];
	logic [DIST_WIDTH-1:0]          ch_dist_q [NUM_CELLS+1];
	logic [IDX_WIDTH-1:0]           ch_idx_i  [NUM_CELLS+1];
	logic [IDX_WIDTH-1:0]           ch_idx_q  [NUM_CELLS+1];

	qnd_cfg #(
		.IDX_WIDTH (IDX_WIDTH)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.write_enable (write_enable),
		.write_index  (write_index),
		.write_data   (write_data),
		.ctl          (ctl),
		.levels       (levels)
	);

	assign ch_valid[0]  = sample_valid;
	assign sample_stall = !ch_ready[0];
	assign ch_i[0]      = in_phase;
	assign ch_q[0]      = quadrature;
	assign ch_dist_i[0] = '0;
	assign ch_dist_q[0] = '0;
	assign ch_idx_i[0]  = '0;
	assign ch_idx_q[0]  = '0;

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		qnd_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.IDX_WIDTH    (IDX_WIDTH),
			.DIST_WIDTH   (DIST_WIDTH),
			.CELL_INDEX   (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.level     ($signed(levels[k])),
			.up_valid  (ch_valid[k]),
			.up_ready  (ch_ready[k]),
			.up_i      (ch_i[k]),
			.up_q      (ch_q[k]),
			.up_dist_i (ch_dist_i[k]),
			.up_dist_q (ch_dist_q[k]),
			.up_idx_i  (ch_idx_i[k]),
			.up_idx_q  (ch_idx_q[k]),
			.dn_valid  (ch_valid[k+1]),
			.dn_ready  (ch_ready[k+1]),
			.dn_i      (ch_i[k+1]),
			.dn_q      (ch_q[k+1]),
			.dn_dist_i (ch_dist_i[k+1]),
			.dn_dist_q (ch_dist_q[k+1]),
			.dn_idx_i  (ch_idx_i[k+1]),
			.dn_idx_q  (ch_idx_q[k+1])
		);
	end

	assign symbol_valid        = ch_valid[NUM_CELLS];
	assign ch_ready[NUM_CELLS] = !symbol_stall;

	// Interleave: I level bits go to even positions, Q level bits to odd ones.
	always_comb begin
		symbol_bits = '0;
		for (int b = 0; b < IDX_WIDTH; b++) begin
			symbol_bits[2*b]     = ch_idx_i[NUM_CELLS][b];
			symbol_bits[2*b + 1] = ch_idx_q[NUM_CELLS][b];
		end
	end

	assign bit_count = ctl.bit_count;

endmodule

`default_nettype wire
